### rtl/esc_power_ramp_limiter_core_defines.svh
// Assertion macros used by the RTL of the power ramp limiter.
`ifndef ESC_POWER_RAMP_LIMITER_CORE_DEFINES_SVH
`define ESC_POWER_RAMP_LIMITER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ESC_PRL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ESC_PRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/esc_prl_pkg.sv
`default_nettype none

package esc_prl_pkg;

   localparam int FUNC_W      = 2;
   localparam int REQ_POWER_W = 16;
   localparam int TIME_W      = 32;
   localparam int PULSE_W     = 11;
   localparam int STEP_W      = 13;
   localparam int RATE_W      = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam int RATE_FRAC_BITS = 20;

   localparam int MUL_A_W = TIME_W + 1;
   localparam int MUL_B_W = RATE_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [STEP_W-1:0] STEP_LIMIT_RESET  = STEP_W'(410);
   localparam logic [RATE_W-1:0] RATE_PER_MS_RESET = RATE_W'(4096);

   localparam int PULSE_CENTER_US = 1500;
   localparam int PULSE_SPAN_US   = 400;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SET_POWER = 2'd0,
      FUNC_ARM       = 2'd1,
      FUNC_DISARM    = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_LIMIT  = 1'b0,
      CSR_RATE_PER_MS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_APPLY,
      ST_PULSE
   } state_type;

endpackage

`default_nettype wire

### rtl/esc_prl_if.sv
`default_nettype none

interface esc_prl_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [esc_prl_pkg::FUNC_W-1:0]           func;
   logic signed [esc_prl_pkg::REQ_POWER_W-1:0] requested_power;
   logic [esc_prl_pkg::TIME_W-1:0]           now_ms;

   modport source (output valid, func, requested_power, now_ms, input ready);
   modport sink (input valid, func, requested_power, now_ms, output ready);
endinterface

interface esc_prl_rsp_if #(parameter int POWER_FRAC_BITS = 12);
   logic                               valid;
   logic                               ready;
   logic signed [POWER_FRAC_BITS+1:0]  applied_power;
   logic [esc_prl_pkg::PULSE_W-1:0]    pulse_us;
   logic                               pulse_written;
   logic                               is_armed;

   modport source (output valid, applied_power, pulse_us, pulse_written, is_armed,
                   input ready);
   modport sink (input valid, applied_power, pulse_us, pulse_written, is_armed,
                 output ready);
endinterface

interface esc_prl_csr_if;
   logic                                valid;
   logic                                ready;
   logic [esc_prl_pkg::CSR_IDX_W-1:0]   index;
   logic [esc_prl_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/esc_power_ramp_limiter_core.sv
`default_nettype none
`include "esc_power_ramp_limiter_core_defines.svh"

// Slew-rate limited ESC throttle. Each command word (set power, arm, disarm) yields one
// response word with the applied power, the pulse width 1500 + power*400/2^POWER_FRAC_BITS
// microseconds, a flag telling whether a new pulse was issued and the armed flag. A set power
// command that moves the power goes through accept, elapsed-time scaling, ramp update and
// pulse computation; every other command goes through accept and pulse computation. One shared
// 33x17 multiplier serves both the time scaling and the pulse computation, and the block
// accepts no command while it works. The response sits in an output register, so a new
// command is taken while it waits; the block holds in the pulse step only when the earlier
// response is still waiting there.
// The configuration registers are written through the csr channel, which is always ready.

module esc_power_ramp_limiter_core #(
   parameter int POWER_FRAC_BITS = 12
) (
   input wire logic                  clock,
   input wire logic                  reset,
   esc_prl_req_if.sink               req_chan,
   esc_prl_rsp_if.source             rsp_chan,
   esc_prl_csr_if.sink               csr_chan
);

   localparam int PW     = POWER_FRAC_BITS + 2;
   localparam int CW     = ((PW > esc_prl_pkg::REQ_POWER_W) ? PW : esc_prl_pkg::REQ_POWER_W)
                           + 2;
   localparam int SHIFT  = esc_prl_pkg::RATE_FRAC_BITS - POWER_FRAC_BITS;
   localparam int PROD_W = esc_prl_pkg::MUL_P_W;
   localparam int BYT_W  = PROD_W - SHIFT;
   localparam int ONE_INT = 1 << POWER_FRAC_BITS;
   localparam logic signed [CW-1:0] ONE_C     = CW'(ONE_INT);
   localparam logic signed [CW-1:0] NEG_ONE_C = -CW'(ONE_INT);

   esc_prl_pkg::state_type state_ff, state_in;

   logic [esc_prl_pkg::STEP_W-1:0] step_ff;
   logic [esc_prl_pkg::RATE_W-1:0] rate_ff;

   logic signed [PW-1:0]            target_ff, target_in;
   logic signed [PW-1:0]            present_ff, present_in;
   logic [esc_prl_pkg::TIME_W-1:0]  last_ff, last_in;
   logic                            ever_ff, ever_in;
   logic                            armed_ff, armed_in;
   logic [esc_prl_pkg::TIME_W-1:0]  now_ff, now_in;
   logic                            written_ff, written_in;
   logic signed [PROD_W-1:0]        prod_ff, prod_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [PW-1:0]            rsp_power_ff, rsp_power_in;
   logic [esc_prl_pkg::PULSE_W-1:0] rsp_pulse_ff, rsp_pulse_in;
   logic                            rsp_written_ff, rsp_written_in;
   logic                            rsp_armed_ff, rsp_armed_in;

   logic                                 req_fire;
   logic                                 out_free;
   logic signed [CW-1:0]                 req_ext;
   logic signed [CW-1:0]                 req_clamp;
   logic                                 set_moves;
   logic [esc_prl_pkg::TIME_W-1:0]       elapsed;
   logic signed [esc_prl_pkg::MUL_A_W-1:0] mul_a;
   logic signed [esc_prl_pkg::MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]             mul_p;
   logic signed [PROD_W-1:0]             pulse_scaled;
   logic [esc_prl_pkg::PULSE_W:0]        pulse_sum;
   logic [BYT_W-1:0]                     by_time;
   logic [esc_prl_pkg::STEP_W-1:0]       inc;
   logic signed [CW-1:0]                 t_c, p_c, s_c, inc_c, ramp_c;

   assign req_chan.ready = (state_ff == esc_prl_pkg::ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_ext   = CW'(req_chan.requested_power);
   assign req_clamp = (req_ext > ONE_C) ? ONE_C
                      : ((req_ext < NEG_ONE_C) ? NEG_ONE_C : req_ext);
   assign set_moves = armed_ff && (PW'(req_clamp) != present_ff);

   assign elapsed = now_ff - last_ff;

   always_comb begin
      if (state_ff == esc_prl_pkg::ST_PULSE) begin
         mul_a = esc_prl_pkg::MUL_A_W'(present_ff);
         mul_b = esc_prl_pkg::MUL_B_W'(esc_prl_pkg::PULSE_SPAN_US);
      end else begin
         mul_a = esc_prl_pkg::MUL_A_W'(elapsed);
         mul_b = esc_prl_pkg::MUL_B_W'(rate_ff);
      end
   end

   assign mul_p = mul_a * mul_b;
   assign pulse_scaled = mul_p >>> POWER_FRAC_BITS;
   assign pulse_sum = (esc_prl_pkg::PULSE_W + 1)'(pulse_scaled)
                      + (esc_prl_pkg::PULSE_W + 1)'(esc_prl_pkg::PULSE_CENTER_US);

   assign by_time = prod_ff[PROD_W-1:SHIFT];
   assign inc     = (by_time < BYT_W'(step_ff)) ? by_time[esc_prl_pkg::STEP_W-1:0] : step_ff;
   assign t_c     = CW'(target_ff);
   assign p_c     = CW'(present_ff);
   assign s_c     = CW'(step_ff);
   assign inc_c   = CW'(inc);

   always_comb begin
      if (t_c == '0) begin
         ramp_c = '0;
      end else if (!ever_ff || (p_c > 0 && t_c < 0) || (p_c < 0 && t_c > 0)) begin
         if (t_c > 0) begin
            ramp_c = (t_c < s_c) ? t_c : s_c;
         end else begin
            ramp_c = (t_c > -s_c) ? t_c : -s_c;
         end
      end else if ((t_c > 0 && t_c < p_c) || (t_c < 0 && t_c > p_c)) begin
         ramp_c = t_c;
      end else if (t_c > 0) begin
         ramp_c = (t_c < p_c + inc_c) ? t_c : p_c + inc_c;
      end else begin
         ramp_c = (t_c > p_c - inc_c) ? t_c : p_c - inc_c;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         esc_prl_pkg::ST_IDLE: begin
            if (req_fire) begin
               if ((esc_prl_pkg::func_type'(req_chan.func) == esc_prl_pkg::FUNC_SET_POWER)
                   && set_moves) begin
                  state_in = esc_prl_pkg::ST_SCALE;
               end else begin
                  state_in = esc_prl_pkg::ST_PULSE;
               end
            end
         end
         esc_prl_pkg::ST_SCALE: begin
            state_in = esc_prl_pkg::ST_APPLY;
         end
         esc_prl_pkg::ST_APPLY: begin
            state_in = esc_prl_pkg::ST_PULSE;
         end
         esc_prl_pkg::ST_PULSE: begin
            if (out_free) begin
               state_in = esc_prl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = esc_prl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      target_in      = target_ff;
      present_in     = present_ff;
      last_in        = last_ff;
      ever_in        = ever_ff;
      armed_in       = armed_ff;
      now_in         = now_ff;
      written_in     = written_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_power_in   = rsp_power_ff;
      rsp_pulse_in   = rsp_pulse_ff;
      rsp_written_in = rsp_written_ff;
      rsp_armed_in   = rsp_armed_ff;
      unique case (state_ff)
         esc_prl_pkg::ST_IDLE: begin
            if (req_fire) begin
               now_in     = req_chan.now_ms;
               written_in = 1'b0;
               unique case (esc_prl_pkg::func_type'(req_chan.func))
                  esc_prl_pkg::FUNC_SET_POWER: begin
                     target_in  = PW'(req_clamp);
                     written_in = set_moves;
                  end
                  esc_prl_pkg::FUNC_ARM: begin
                     target_in = '0;
                     armed_in  = 1'b1;
                  end
                  esc_prl_pkg::FUNC_DISARM: begin
                     target_in  = '0;
                     present_in = '0;
                     armed_in   = 1'b0;
                     written_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         esc_prl_pkg::ST_SCALE: begin
            prod_in = mul_p;
         end
         esc_prl_pkg::ST_APPLY: begin
            present_in = PW'(ramp_c);
            last_in    = now_ff;
            ever_in    = 1'b1;
         end
         esc_prl_pkg::ST_PULSE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_power_in   = present_ff;
               rsp_pulse_in   = pulse_sum[esc_prl_pkg::PULSE_W-1:0];
               rsp_written_in = written_ff;
               rsp_armed_in   = armed_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign csr_chan.ready         = 1'b1;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.applied_power = rsp_power_ff;
   assign rsp_chan.pulse_us      = rsp_pulse_ff;
   assign rsp_chan.pulse_written = rsp_written_ff;
   assign rsp_chan.is_armed      = rsp_armed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= esc_prl_pkg::ST_IDLE;
         step_ff      <= esc_prl_pkg::STEP_LIMIT_RESET;
         rate_ff      <= esc_prl_pkg::RATE_PER_MS_RESET;
         target_ff    <= '0;
         present_ff   <= '0;
         last_ff      <= '0;
         ever_ff      <= 1'b0;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         present_ff   <= present_in;
         last_ff      <= last_in;
         ever_ff      <= ever_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            unique case (esc_prl_pkg::csr_index_type'(csr_chan.index))
               esc_prl_pkg::CSR_STEP_LIMIT: begin
                  step_ff <= csr_chan.data[esc_prl_pkg::STEP_W-1:0];
               end
               esc_prl_pkg::CSR_RATE_PER_MS: begin
                  rate_ff <= csr_chan.data[esc_prl_pkg::RATE_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      written_ff     <= written_in;
      prod_ff        <= prod_in;
      rsp_power_ff   <= rsp_power_in;
      rsp_pulse_ff   <= rsp_pulse_in;
      rsp_written_ff <= rsp_written_in;
      rsp_armed_ff   <= rsp_armed_in;
   end

   `ESC_PRL_ASSERT_NOW(a_disarmed_at_rest, clock, reset, !armed_ff, present_ff == '0,
      "Present power is nonzero while disarmed.")
   `ESC_PRL_ASSERT_NOW(a_power_in_range, clock, reset, 1'b1,
      (CW'(present_ff) <= ONE_C) && (CW'(present_ff) >= NEG_ONE_C),
      "Present power is beyond full scale.")
   `ESC_PRL_ASSERT_NEXT(a_disarm_clears, clock, reset,
      req_fire && (req_chan.func == esc_prl_pkg::FUNC_DISARM),
      !armed_ff && (present_ff == '0) && written_ff, "Disarm did not clear the drive.")
   `ESC_PRL_ASSERT_NEXT(a_ever_sticks, clock, reset, ever_ff, ever_ff,
      "Update history was lost.")

endmodule

`default_nettype wire

### verif/tb_esc_power_ramp_limiter_core.sv
`timescale 1ns / 100ps

module tb_esc_power_ramp_limiter_core;
   import esc_prl_pkg::*;

   localparam int FRAC_BITS = 12;
   localparam int POWER_ONE = 1 << FRAC_BITS;
   localparam int APPLIED_W = FRAC_BITS + 2;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1030;
   localparam int NUM_PHASES = 5;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [APPLIED_W-1:0] applied_power;
      logic [PULSE_W-1:0]          pulse_us;
      logic                        pulse_written;
      logic                        is_armed;
   } throttle_word_t;

   class throttle_model;
      logic [STEP_W-1:0] step_limit;
      logic [RATE_W-1:0] rate_per_ms;
      int                target_power;
      int                present_power;
      logic [TIME_W-1:0] last_update_ms;
      bit                ever_updated;
      bit                armed;
      throttle_word_t    pending[$];
      int                mismatches;
      int                commands;
      int                responses;
      int                ramp_updates;

      function new();
         step_limit = STEP_LIMIT_RESET;
         rate_per_ms = RATE_PER_MS_RESET;
         target_power = 0;
         present_power = 0;
         last_update_ms = '0;
         ever_updated = 1'b0;
         armed = 1'b0;
         mismatches = 0;
         commands = 0;
         responses = 0;
         ramp_updates = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_STEP_LIMIT) begin
            step_limit = value[STEP_W-1:0];
         end else begin
            rate_per_ms = value[RATE_W-1:0];
         end
      endfunction

      function bit advance_power(logic [TIME_W-1:0] now);
         logic [TIME_W-1:0] elapsed;
         logic [63:0]       by_time;
         int                limit;
         int                inc;
         limit = int'(step_limit);
         if (present_power == target_power || !armed) return 1'b0;
         if (target_power == 0) begin
            present_power = 0;
         end else if (!ever_updated || (present_power > 0 && target_power < 0) ||
                      (present_power < 0 && target_power > 0)) begin
            if (target_power > 0) begin
               present_power = (target_power < limit) ? target_power : limit;
            end else begin
               present_power = (target_power > -limit) ? target_power : -limit;
            end
         end else if ((target_power > 0 && target_power < present_power) ||
                      (target_power < 0 && target_power > present_power)) begin
            present_power = target_power;
         end else begin
            // Speed-up: bounded by elapsed time times the rate and by the step limit.
            elapsed = now - last_update_ms;
            by_time = (64'(elapsed) * 64'(rate_per_ms)) >> (RATE_FRAC_BITS - FRAC_BITS);
            inc = (by_time < 64'(limit)) ? int'(by_time) : limit;
            if (target_power > 0) begin
               present_power = (present_power + inc < target_power) ?
                               present_power + inc : target_power;
            end else begin
               present_power = (present_power - inc > target_power) ?
                               present_power - inc : target_power;
            end
            ramp_updates++;
         end
         last_update_ms = now;
         ever_updated = 1'b1;
         return 1'b1;
      endfunction

      function void note_command(logic [FUNC_W-1:0] f, logic signed [REQ_POWER_W-1:0] req,
                                 logic [TIME_W-1:0] now);
         int             clamped;
         bit             written;
         throttle_word_t word;
         clamped = int'(req);
         if (clamped > POWER_ONE) clamped = POWER_ONE;
         else if (clamped < -POWER_ONE) clamped = -POWER_ONE;
         written = 1'b0;
         case (f)
            FUNC_SET_POWER: begin
               target_power = clamped;
               written = advance_power(now);
            end
            FUNC_ARM: begin
               target_power = 0;
               armed = 1'b1;
            end
            FUNC_DISARM: begin
               target_power = 0;
               present_power = 0;
               armed = 1'b0;
               written = 1'b1;
            end
            default: begin
            end
         endcase
         word.applied_power = APPLIED_W'(present_power);
         word.pulse_us = PULSE_W'((PULSE_CENTER_US * POWER_ONE + present_power * PULSE_SPAN_US)
                                  / POWER_ONE);
         word.pulse_written = written;
         word.is_armed = armed;
         pending.push_back(word);
         commands++;
      endfunction

      function void check_response(throttle_word_t got);
         throttle_word_t want;
         responses++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Unexpected response word: power %0d pulse %0d written %0b armed %0b",
                        got.applied_power, got.pulse_us, got.pulse_written, got.is_armed);
            return;
         end
         want = pending.pop_front();
         if (got.applied_power !== want.applied_power || got.pulse_us !== want.pulse_us ||
             got.pulse_written !== want.pulse_written || got.is_armed !== want.is_armed) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Mismatch: expected power %0d pulse %0d written %0b armed %0b, %s%0d %s%0d %s%0b %s%0b",
                        want.applied_power, want.pulse_us, want.pulse_written, want.is_armed,
                        "got power ", got.applied_power, "pulse ", got.pulse_us,
                        "written ", got.pulse_written, "armed ", got.is_armed);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   esc_prl_req_if req_if();
   esc_prl_rsp_if #(.POWER_FRAC_BITS(FRAC_BITS)) rsp_if();
   esc_prl_csr_if csr_if();

   esc_power_ramp_limiter_core #(.POWER_FRAC_BITS(FRAC_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   throttle_model model = new();

   bit                             steady_flow;
   int                             rsp_hold;
   int                             cycle_count;
   int                             settings_used;
   logic [TIME_W-1:0]              clock_ms;
   logic signed [REQ_POWER_W-1:0]  last_req;
   throttle_word_t                 seen;

   always #6 clock = ~clock;

   function automatic int draw_gap();
      return steady_flow ? 0 : int'($urandom_range(0, 5));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen.applied_power = rsp_if.applied_power;
            seen.pulse_us = rsp_if.pulse_us;
            seen.pulse_written = rsp_if.pulse_written;
            seen.is_armed = rsp_if.is_armed;
            model.check_response(seen);
            rsp_hold = draw_gap();
         end
         if (rsp_hold > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic [FUNC_W-1:0] f,
                            input logic signed [REQ_POWER_W-1:0] req,
                            input logic [TIME_W-1:0] now);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func <= f;
      req_if.requested_power <= req;
      req_if.now_ms <= now;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      model.note_command(f, req, now);
   endtask

   task automatic write_settings(input logic [CSR_DATA_W-1:0] step_value,
                                 input logic [CSR_DATA_W-1:0] rate_value);
      csr_if.valid <= 1'b1;
      csr_if.index <= CSR_STEP_LIMIT;
      csr_if.data <= step_value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      model.write_reg(CSR_STEP_LIMIT, step_value);
      csr_if.index <= CSR_RATE_PER_MS;
      csr_if.data <= rate_value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      model.write_reg(CSR_RATE_PER_MS, rate_value);
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic drain_responses();
      req_if.valid <= 1'b0;
      while (model.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_directed();
      send_word(FUNC_SET_POWER, 16'sd1000, 32'd5);
      send_word(FUNC_UNUSED, -16'sd5, 32'd7);
      send_word(FUNC_ARM, 16'sd0, 32'd8);
      send_word(FUNC_SET_POWER, 16'sh7FFF, 32'd10);
      send_word(FUNC_SET_POWER, 16'sd4096, 32'd20);
      send_word(FUNC_SET_POWER, 16'sd4096, 32'd1020);
      send_word(FUNC_SET_POWER, 16'sd980, 32'd1030);
      send_word(FUNC_SET_POWER, 16'sd200, 32'd1040);
      send_word(FUNC_SET_POWER, 16'sh8000, 32'd1050);
      send_word(FUNC_SET_POWER, -16'sd4096, 32'd1051);
      send_word(FUNC_SET_POWER, -16'sd4096, 32'd1051);
      send_word(FUNC_SET_POWER, 16'sd0, 32'd1060);
      send_word(FUNC_SET_POWER, 16'sd3000, 32'd1100);
      send_word(FUNC_SET_POWER, 16'sd3000, 32'hFFFF_FFF0);
      send_word(FUNC_SET_POWER, 16'sd3000, 32'h0000_0005);
      send_word(FUNC_SET_POWER, -16'sd1, 32'd6);
      send_word(FUNC_SET_POWER, 16'sd1, 32'd7);
      send_word(FUNC_ARM, 16'sd0, 32'd8);
      send_word(FUNC_UNUSED, 16'sh7FFF, 32'hFFFF_FFFF);
      send_word(FUNC_DISARM, 16'sh8000, 32'd9);
      send_word(FUNC_SET_POWER, 16'sd4096, 32'd10);
      send_word(FUNC_DISARM, 16'sd0, 32'd11);
      send_word(FUNC_ARM, 16'sd0, 32'd12);
      send_word(FUNC_SET_POWER, 16'sd4096, 32'd40);
      send_word(FUNC_SET_POWER, -16'sd4097, 32'd41);
   endtask

   task automatic run_random(input int count);
      logic [FUNC_W-1:0]             f;
      logic signed [REQ_POWER_W-1:0] req;
      int                            pick;
      for (int i = 0; i < count; i++) begin
         steady_flow = ((i / 50) % 4) == 3;
         pick = $urandom_range(0, 99);
         if (!model.armed && $urandom_range(0, 3) != 0) f = FUNC_ARM;
         else if (pick < 80) f = FUNC_SET_POWER;
         else if (pick < 88) f = FUNC_ARM;
         else if (pick < 95) f = FUNC_DISARM;
         else f = FUNC_UNUSED;
         case ($urandom_range(0, 9))
            0: req = REQ_POWER_W'($urandom());
            1: begin
               case ($urandom_range(0, 3))
                  0: req = 16'sh7FFF;
                  1: req = 16'sh8000;
                  2: req = 16'sd4096;
                  default: req = -16'sd4096;
               endcase
            end
            2: req = '0;
            3, 4, 5: req = last_req;
            default: req = REQ_POWER_W'($urandom_range(0, 2 * POWER_ONE) - POWER_ONE);
         endcase
         last_req = req;
         case ($urandom_range(0, 19))
            0: clock_ms = $urandom();
            1: begin
            end
            2: clock_ms = clock_ms + $urandom_range(0, 5000);
            default: clock_ms = clock_ms + $urandom_range(1, 60);
         endcase
         send_word(f, req, clock_ms);
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles.", cycle_count);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int failures;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.func = FUNC_SET_POWER;
      req_if.requested_power = '0;
      req_if.now_ms = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_STEP_LIMIT;
      csr_if.data = '0;
      steady_flow = 1'b0;
      settings_used = 1;
      clock_ms = '0;
      last_req = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      run_directed();
      drain_responses();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: write_settings(16'd0, 16'd0);
            1: write_settings(16'd4096, 16'hFFFF);
            2: write_settings(16'd1, 16'd1);
            3: write_settings(CSR_DATA_W'($urandom_range(0, 4096)),
                              CSR_DATA_W'($urandom_range(0, 65535)));
            default: write_settings(16'd410, 16'd4096);
         endcase
         run_random(RANDOM_ITEMS / NUM_PHASES);
         drain_responses();
      end

      repeat (16) @(posedge clock);
      failures = model.mismatches + model.pending.size();
      $display("Checked %0d response words for %0d commands under %0d register settings.",
               model.responses, model.commands, settings_used);
      $display("%0d set-power updates were limited by elapsed time or the step limit.",
               model.ramp_updates);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d failures.", failures);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
